// ===== design/lrc_pkg.sv =====
// Shared sizes and the recency update word for the LRU cache
package lrc_pkg;

    localparam int ENTRIES    = 16;
    localparam int DATA_WIDTH = 32;
    localparam int KEY_W      = 32;
    localparam int WORD_W     = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 5;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LVL_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (LVL_W > CFG_W) ? LVL_W : CFG_W;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] old_rank;
        logic             all;
    } t_rank_upd;

endpackage

// ===== design/lrc_ram.sv =====
// Generic single write, single read RAM with registered read data
module lrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/lrc_rank.sv =====
// Recency rank per slot, read at the scan index, aged in parallel on update
module lrc_rank import lrc_pkg::*; (
    input  logic             i_clk,
    input  t_rank_upd        i_upd,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [IDX_W-1:0] o_rd_rank
);

    logic [IDX_W-1:0] r_rank [ENTRIES];

    // ranks of unfilled slots are don't-care; they get 0 when the slot fills
    always_ff @(posedge i_clk) begin
        if (i_upd.en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == i_upd.slot) begin
                    r_rank[i] <= '0;
                end else if (i_upd.all || (r_rank[i] < i_upd.old_rank)) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
        end
    end

    assign o_rd_rank = r_rank[i_rd_idx];

endmodule

// ===== design/lru_cache_hit_counter.sv =====
// LRU cache with hit counter: each request runs through the scan, decide and output states before the next accept.
// The result word is loaded into the output register in the output state once that register is free.
// The tag scan reads one tag per cycle from the tag RAM, with the tag arriving in the cycle after its address,
// so the scan covers every filled slot and then moves on to the decide state.
// The result word is registered and may wait while the next request is taken.
// Synchronous active-low reset empties the cache, clears the hit count and sets capacity 16.
module lru_cache_hit_counter import lrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_in_stall,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [WORD_W-1:0] i_fill_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic [WORD_W-1:0] o_data,
    output logic [CNT_W-1:0]  o_hit_count,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DEC, S_OUT} t_state;

    t_state                r_state;
    logic [KEY_W-1:0]      r_key;
    logic [DATA_WIDTH-1:0] r_fill;
    logic [LVL_W-1:0]      r_idx;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_slot;
    logic [IDX_W-1:0]      r_old_rank;
    logic [IDX_W-1:0]      r_victim;
    logic [LVL_W-1:0]      r_fill_lvl;
    logic [CNT_W-1:0]      r_hit_cnt;
    logic [CFG_W-1:0]      r_capacity;
    logic                  r_out_vld;
    logic                  r_out_hit;
    logic [WORD_W-1:0]     r_out_data;
    logic [CNT_W-1:0]      r_out_cnt;

    logic                  accept;
    logic                  tag_rd_en;
    logic [KEY_W-1:0]      tag_rd;
    logic [DATA_WIDTH-1:0] data_rd;
    logic [IDX_W-1:0]      rank_rd;
    logic [CMP_W-1:0]      cap_lim;
    logic                  miss_fill;
    logic                  store_wr;
    logic [IDX_W-1:0]      w_slot;
    logic [LVL_W-1:0]      last_lvl;
    logic                  out_free;
    t_rank_upd             rank_upd;

    assign accept     = i_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign tag_rd_en = (r_state == S_SCAN) && (r_idx < r_fill_lvl);
    assign last_lvl  = r_fill_lvl - LVL_W'(1);

    always_comb begin
        if (r_capacity == '0) begin
            cap_lim = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(ENTRIES)) begin
            cap_lim = CMP_W'(ENTRIES);
        end else begin
            cap_lim = CMP_W'(r_capacity);
        end
    end

    assign miss_fill = !r_found && (CMP_W'(r_fill_lvl) < cap_lim);
    assign store_wr  = (r_state == S_DEC) && !r_found;

    always_comb begin
        if (r_found) begin
            w_slot = r_slot;
        end else if (miss_fill) begin
            w_slot = r_fill_lvl[IDX_W-1:0];
        end else begin
            w_slot = r_victim;
        end
    end

    // victim rank is always the oldest, fill level minus one
    always_comb begin
        rank_upd.en       = (r_state == S_DEC);
        rank_upd.slot     = w_slot;
        rank_upd.old_rank = r_found ? r_old_rank : last_lvl[IDX_W-1:0];
        rank_upd.all      = miss_fill;
    end

    assign out_free = !r_out_vld || !i_out_stall;

    lrc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (w_slot),
        .i_wr_data (r_key),
        .i_rd_en   (tag_rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (tag_rd)
    );

    lrc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (w_slot),
        .i_wr_data (r_fill),
        .i_rd_en   ((r_state == S_DEC) && r_found),
        .i_rd_addr (r_slot),
        .o_rd_data (data_rd)
    );

    lrc_rank u_rank (
        .i_clk     (i_clk),
        .i_upd     (rank_upd),
        .i_rd_idx  (r_cmp_idx),
        .o_rd_rank (rank_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmp_vld  <= 1'b0;
            r_fill_lvl <= '0;
            r_hit_cnt  <= '0;
            r_capacity <= CFG_W'(16);
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            // the output stage reloads the result register itself
            if (r_out_vld && !i_out_stall && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key     <= i_key;
                        r_fill    <= DATA_WIDTH'(i_fill_data);
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_found   <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // compare stage runs one slot behind the tag read address
                    if (r_cmp_vld) begin
                        if (!r_found && (tag_rd == r_key)) begin
                            r_found    <= 1'b1;
                            r_slot     <= r_cmp_idx;
                            r_old_rank <= rank_rd;
                        end
                        if (LVL_W'(rank_rd) == last_lvl) begin
                            r_victim <= r_cmp_idx;
                        end
                    end
                    r_cmp_vld <= tag_rd_en;
                    r_cmp_idx <= r_idx[IDX_W-1:0];
                    if (tag_rd_en) begin
                        r_idx <= r_idx + LVL_W'(1);
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_found && (r_hit_cnt != '1)) begin
                        r_hit_cnt <= r_hit_cnt + CNT_W'(1);
                    end
                    if (miss_fill) begin
                        r_fill_lvl <= r_fill_lvl + LVL_W'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_hit  <= r_found;
                        r_out_data <= r_found ? WORD_W'(data_rd) : WORD_W'(r_fill);
                        r_out_cnt  <= r_hit_cnt;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_hit       = r_out_hit;
    assign o_data      = r_out_data;
    assign o_hit_count = r_out_cnt;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_fill_lvl) <= CMP_W'(ENTRIES))
        else $error("fill level beyond slot count");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted word did not start a scan");

    a_hit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DEC) && r_found) |-> (LVL_W'(r_slot) < r_fill_lvl))
        else $error("hit on an unfilled slot");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DEC) |=> $stable(r_hit_cnt))
        else $error("hit count moved outside decide");

endmodule

// ===== tb/sv/lrc_checker.sv =====
// Checker for the LRU cache: tracks the cache contents, predicts each result word and compares
module lrc_checker import lrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_in_stall,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [WORD_W-1:0] i_fill_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_hit,
    input  logic [WORD_W-1:0] i_data,
    input  logic [CNT_W-1:0]  i_hit_count,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_hits
);

    typedef struct {
        logic              hit;
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  hit_count;
    } t_lookup;

    logic [KEY_W-1:0]  tag_mem  [ENTRIES];
    logic [WORD_W-1:0] word_mem [ENTRIES];
    int unsigned       age      [ENTRIES];
    int                fill_cnt;
    logic [CNT_W-1:0]  hit_total;
    logic [CFG_W-1:0]  cap_reg;
    t_lookup           due_lookups[$];
    int                errors;
    int                hits_seen;

    assign o_errors  = errors;
    assign o_pending = due_lookups.size();
    assign o_hits    = hits_seen;

    // slot s becomes most recent; filled slots newer than it age by one
    task automatic make_newest(input int s, input int unsigned old_age);
        for (int i = 0; i < fill_cnt; i++) begin
            if (i != s && age[i] < old_age) age[i]++;
        end
        age[s] = 0;
    endtask

    task automatic cache_lookup(input logic [KEY_W-1:0] key, input logic [WORD_W-1:0] fill,
                                output t_lookup res);
        int          slot;
        int          victim;
        int unsigned worst;
        int          eff_cap;
        bit          found;
        found   = 1'b0;
        slot    = 0;
        eff_cap = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
        for (int i = 0; i < fill_cnt; i++) begin
            if (!found && tag_mem[i] == key) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            if (hit_total != '1) hit_total++;
            make_newest(slot, age[slot]);
            res.data = word_mem[slot];
        end else if (fill_cnt < eff_cap) begin
            slot = fill_cnt;
            fill_cnt++;
            tag_mem[slot]  = key;
            word_mem[slot] = fill;
            make_newest(slot, 32'hFFFF_FFFF);
            res.data = fill;
        end else begin
            // evict the oldest among every filled slot, even above a lowered capacity
            victim = 0;
            worst  = 0;
            for (int i = 0; i < fill_cnt; i++) begin
                if (age[i] >= worst) begin
                    worst  = age[i];
                    victim = i;
                end
            end
            tag_mem[victim]  = key;
            word_mem[victim] = fill;
            make_newest(victim, worst);
            res.data = fill;
        end
        res.hit       = found;
        res.hit_count = hit_total;
    endtask

    always @(posedge i_clk) begin : p_model
        t_lookup exp_word;
        t_lookup new_word;
        if (!i_rst_n) begin
            fill_cnt  = 0;
            hit_total = '0;
            cap_reg   = CFG_W'(ENTRIES);
            due_lookups.delete();
            errors    = 0;
            hits_seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) cap_reg = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (due_lookups.size() == 0) begin
                    $error("result word with no request outstanding");
                    errors++;
                end else begin
                    exp_word = due_lookups.pop_front();
                    if (i_hit !== exp_word.hit) begin
                        $error("hit: expected %0d, got %0d", exp_word.hit, i_hit);
                        errors++;
                    end
                    if (i_data !== exp_word.data) begin
                        $error("data: expected %h, got %h", exp_word.data, i_data);
                        errors++;
                    end
                    if (i_hit_count !== exp_word.hit_count) begin
                        $error("hit_count: expected %0d, got %0d",
                               exp_word.hit_count, i_hit_count);
                        errors++;
                    end
                    if (exp_word.hit) hits_seen++;
                end
            end
            if (i_valid && !i_in_stall) begin
                cache_lookup(i_key, i_fill_data, new_word);
                due_lookups.push_back(new_word);
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the LRU cache: clock, reset, request and capacity stimulus, verdict
module tb;
    import lrc_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_in_stall;
    logic [KEY_W-1:0]  i_key;
    logic [WORD_W-1:0] i_fill_data;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_hit;
    logic [WORD_W-1:0] o_data;
    logic [CNT_W-1:0]  o_hit_count;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;

    int errors;
    int pending;
    int hits;
    int n_requests;
    int n_cap_writes;
    bit idle_on;

    logic [KEY_W-1:0] key_pool [24];

    lru_cache_hit_counter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_in_stall  (o_in_stall),
        .i_key       (i_key),
        .i_fill_data (i_fill_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_data      (o_data),
        .o_hit_count (o_hit_count),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    lrc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_stall  (o_in_stall),
        .i_key       (i_key),
        .i_fill_data (i_fill_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_hit       (o_hit),
        .i_data      (o_data),
        .i_hit_count (o_hit_count),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_hits      (hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side back-pressure in random bursts
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // valid stays high across back-to-back words; only a gap lowers it
    task automatic lookup_word(input logic [KEY_W-1:0] key, input logic [WORD_W-1:0] fill);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_key       <= key;
        i_fill_data <= fill;
        do @(posedge i_clk); while (o_in_stall);
        n_requests++;
    endtask

    // step the clock before polling so the checker has logged the last accepted word
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] cap);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cap_writes++;
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] cap, input int count);
        int                sel;
        logic [KEY_W-1:0]  key;
        set_capacity(cap);
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
                key = $urandom();
            else if (sel < 13)
                key = (sel[0]) ? '1 : '0;
            else
                key = key_pool[$urandom_range(0, $urandom_range(0, 23))];
            lookup_word(key, $urandom());
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_key        <= '0;
        i_fill_data  <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        idle_on      = 1'b1;
        n_requests   = 0;
        n_cap_writes = 0;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at reset capacity, then hits on them
        lookup_word(32'h0000_0000, 32'h0000_0000);
        lookup_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        lookup_word(32'h0000_0000, 32'hAAAA_AAAA);
        lookup_word(32'hFFFF_FFFF, 32'h0000_0000);
        lookup_word(32'h8000_0000, 32'h5555_5555);
        lookup_word(32'h0000_0001, 32'h8000_0001);
        lookup_word(32'h0000_0000, 32'h1234_5678);
        // capacity lowered under the fill level: misses evict the oldest of all four
        set_capacity(5'd2);
        lookup_word(32'hDEAD_BEEF, 32'hCAFE_F00D);
        lookup_word(32'hFFFF_FFFF, 32'h0F0F_0F0F);
        lookup_word(32'h1357_9BDF, 32'hF0F0_F0F0);
        lookup_word(32'hDEAD_BEEF, 32'h0000_0000);
        // zero capacity behaves as one
        set_capacity(5'd0);
        lookup_word(32'h2468_ACE0, 32'h7FFF_FFFF);
        lookup_word(32'h2468_ACE0, 32'h0000_0000);
        lookup_word(32'h0000_0000, 32'h0000_0000);
        // capacity above the slot count saturates
        set_capacity(5'd31);
        lookup_word(32'h7FFF_FFFF, 32'h8000_0000);
        lookup_word(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        set_capacity(5'd1);
        lookup_word(32'h4000_0000, 32'h1111_1111);
        lookup_word(32'h4000_0000, 32'h2222_2222);
        lookup_word(32'h4000_0001, 32'h3333_3333);

        random_phase(5'd16, 100);
        random_phase(5'd1, 100);
        random_phase(5'd7, 100);
        random_phase(5'd31, 100);
        random_phase(5'd0, 100);
        random_phase(5'd4, 100);
        random_phase(CFG_W'($urandom_range(0, 31)), 100);
        random_phase(5'd12, 100);
        idle_on = 1'b0;
        random_phase(5'd16, 100);

        drain();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d lookups (%0d hits) over %0d capacity settings,",
                 n_requests, hits, n_cap_writes);
        $display("including zero, one, full and oversized capacity and a capacity cut.");
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
